@@ sv/sach_pkg.sv @@
// Package for the set-associative cache hit classifier.
// Holds geometry constants, the per-set memory row type, control structs and the FSM state type.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package sach_pkg;

  // Cache geometry.
  localparam int LINE_BYTES  = 64;
  localparam int NUM_SETS    = 4096;
  localparam int NUM_WAYS    = 12;
  localparam int ADDR_BITS   = 48;

  // Derived address split and field widths.
  localparam int OFFSET_BITS = $clog2(LINE_BYTES);
  localparam int SET_BITS    = $clog2(NUM_SETS);
  localparam int TAG_BITS    = ADDR_BITS - OFFSET_BITS - SET_BITS;
  localparam int WAY_BITS    = 4;
  localparam int CNT_BITS    = 40;
  localparam int LFSR_BITS   = 16;

  localparam logic [CNT_BITS-1:0]  CNT_MAX   = '1;
  localparam logic [LFSR_BITS-1:0] LFSR_TAPS = 16'hB400;
  localparam logic [LFSR_BITS-1:0] LFSR_SEED = 16'h0001;

  // Replacement mode codes.
  localparam logic MODE_LRU    = 1'b0;
  localparam logic MODE_RANDOM = 1'b1;

  // One memory row holds everything about one set.
  // order[0] is the least recently used way, order[NUM_WAYS-1] the most recent.
  typedef struct packed {
    logic [NUM_WAYS-1:0][WAY_BITS-1:0] order;
    logic [NUM_WAYS-1:0]               valid;
    logic [NUM_WAYS-1:0][TAG_BITS-1:0] tag;
  } sach_row_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_wr;
    logic accept;
    logic look;
    logic upd;
  } sach_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic out_free;
  } sach_sts_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_UPD
  } sach_state_t;

  // Row value after reset: all lines empty, recency in way order.
  function automatic sach_row_t clear_row();
    sach_row_t r;
    r = '0;
    for (int k = 0; k < NUM_WAYS; k++) begin
      r.order[k] = WAY_BITS'(k);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/sach_if.sv @@
// Valid/ready channel interfaces for the request address and the classification result.
// Depends on sach_pkg for field widths.
`default_nettype none

interface sach_req_if;
  import sach_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ADDR_BITS-1:0] byte_address;

  modport source (output valid, output byte_address, input ready);
  modport sink   (input valid, input byte_address, output ready);
endinterface

interface sach_rsp_if;
  import sach_pkg::*;
  logic                valid;
  logic                ready;
  logic                was_hit;
  logic [WAY_BITS-1:0] way_used;
  logic [CNT_BITS-1:0] access_total;
  logic [CNT_BITS-1:0] hit_total;

  modport source (output valid, output was_hit, output way_used, output access_total,
                  output hit_total, input ready);
  modport sink   (input valid, input was_hit, input way_used, input access_total,
                  input hit_total, output ready);
endinterface

`default_nettype wire

@@ sv/sach_ctrl.sv @@
// Sequencing state machine for the cache classifier: clearing pass, accept, lookup, update.
// Depends on sach_pkg for the state, command and status types.
`default_nettype none

module sach_ctrl
  import sach_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_ready,
  input  wire sach_sts_t sts,
  output sach_cmd_t      cmd
);

  sach_state_t state;
  sach_state_t state_next;

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (sts.clr_last) state_next = ST_IDLE;
      ST_IDLE:  if (req_valid)    state_next = ST_LOOK;
      ST_LOOK:                    state_next = ST_UPD;
      ST_UPD:   if (sts.out_free) state_next = ST_IDLE;
      default:                    state_next = ST_CLEAR;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      ST_CLEAR: cmd.clr_wr = 1'b1;
      ST_IDLE: begin
        req_ready  = 1'b1;
        cmd.accept = req_valid;
      end
      ST_LOOK:  cmd.look = 1'b1;
      ST_UPD:   cmd.upd  = sts.out_free;
      default:  cmd      = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ sv/sach_dp.sv @@
// Datapath of the cache classifier: set memory, tag compare, victim choice, recency update,
// LFSR, saturating counters and the result register. Depends on sach_pkg and sach_if.
`default_nettype none

module sach_dp
  import sach_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire sach_cmd_t            cmd,
  output sach_sts_t                 sts,
  input  wire logic [ADDR_BITS-1:0] req_addr,
  input  wire logic                 cfg_wr_en,
  input  wire logic                 cfg_wr_data,
  sach_rsp_if.source                rsp
);

  localparam int        MOD_SH = 20;
  localparam logic [MOD_SH:0] RECIP = (MOD_SH+1)'((1 << MOD_SH) / NUM_WAYS);
  localparam sach_row_t CLEAR_ROW = clear_row();

  // Set memory and its registered read port.
  sach_row_t mem [NUM_SETS];
  sach_row_t rd_row;

  logic [SET_BITS-1:0]  clr_addr;
  logic [SET_BITS-1:0]  set_r;
  logic [TAG_BITS-1:0]  tag_r;
  logic                 replace_mode;
  logic [LFSR_BITS-1:0] lfsr;
  logic [LFSR_BITS-1:0] lfsr_q;
  logic [CNT_BITS-1:0]  access_cnt;
  logic [CNT_BITS-1:0]  hit_cnt;
  logic                 hit_r;
  logic [WAY_BITS-1:0]  way_r;

  logic                        look_hit;
  logic [WAY_BITS-1:0]         look_way;
  logic [WAY_BITS-1:0]         lru_way;
  logic [LFSR_BITS-1:0]        lfsr_rem;
  logic [LFSR_BITS-1:0]        lfsr_rem_fix;
  logic [MOD_SH+LFSR_BITS:0]   recip_prod;
  logic [WAY_BITS-1:0]         mru_pos;
  sach_row_t                   row_next;
  logic [CNT_BITS-1:0]         access_next;
  logic [CNT_BITS-1:0]         hit_next;
  logic [LFSR_BITS-1:0]        lfsr_next;
  logic                        rsp_valid;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      replace_mode <= MODE_LRU;
    end else if (cfg_wr_en) begin
      replace_mode <= cfg_wr_data;
    end
  end

  // Clearing pass address.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Memory write: clearing pass or write-back of the updated set.
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[clr_addr] <= CLEAR_ROW;
    end else if (cmd.upd) begin
      mem[set_r] <= row_next;
    end
  end

  // Memory read and address capture on each accepted transfer.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_row <= mem[req_addr[OFFSET_BITS +: SET_BITS]];
      set_r  <= req_addr[OFFSET_BITS +: SET_BITS];
      tag_r  <= req_addr[OFFSET_BITS+SET_BITS +: TAG_BITS];
    end
  end

  // Quotient of the LFSR by the way count, by reciprocal; settles while the block is idle.
  assign recip_prod = (MOD_SH+LFSR_BITS+1)'(lfsr) * (MOD_SH+LFSR_BITS+1)'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr_q <= '0;
    end else begin
      lfsr_q <= recip_prod[MOD_SH +: LFSR_BITS];
    end
  end

  // Remainder with one correction step.
  always_comb begin
    lfsr_rem = lfsr - LFSR_BITS'(lfsr_q * LFSR_BITS'(NUM_WAYS));
    if (lfsr_rem >= LFSR_BITS'(NUM_WAYS)) begin
      lfsr_rem_fix = lfsr_rem - LFSR_BITS'(NUM_WAYS);
    end else begin
      lfsr_rem_fix = lfsr_rem;
    end
  end

  // Tag compare: the lowest valid matching way wins.
  always_comb begin
    look_hit = 1'b0;
    look_way = '0;
    for (int k = NUM_WAYS - 1; k >= 0; k--) begin
      if (rd_row.valid[k] && (rd_row.tag[k] == tag_r)) begin
        look_hit = 1'b1;
        look_way = WAY_BITS'(k);
      end
    end
    if (rd_row.order[0] >= WAY_BITS'(NUM_WAYS)) begin
      lru_way = '0;
    end else begin
      lru_way = rd_row.order[0];
    end
  end

  // Lookup result register.
  always_ff @(posedge clk) begin
    if (cmd.look) begin
      hit_r <= look_hit;
      if (look_hit) begin
        way_r <= look_way;
      end else if (replace_mode == MODE_RANDOM) begin
        way_r <= lfsr_rem_fix[WAY_BITS-1:0];
      end else begin
        way_r <= lru_way;
      end
    end
  end

  // Updated row: refill on a miss; on a hit or in LRU mode, move the used way to the most recent place.
  always_comb begin
    row_next = rd_row;
    mru_pos  = '0;
    for (int k = 0; k < NUM_WAYS; k++) begin
      if (rd_row.order[k] == way_r) begin
        mru_pos = WAY_BITS'(k);
      end
    end
    if (!hit_r) begin
      row_next.tag[way_r]   = tag_r;
      row_next.valid[way_r] = 1'b1;
    end
    if (hit_r || (replace_mode == MODE_LRU)) begin
      for (int k = 0; k < NUM_WAYS - 1; k++) begin
        if (WAY_BITS'(k) >= mru_pos) begin
          row_next.order[k] = rd_row.order[k+1];
        end
      end
      row_next.order[NUM_WAYS-1] = way_r;
    end
  end

  // Counter and LFSR next values.
  always_comb begin
    access_next = (access_cnt == CNT_MAX) ? access_cnt : access_cnt + 1'b1;
    hit_next    = hit_cnt;
    if (hit_r && (hit_cnt != CNT_MAX)) begin
      hit_next = hit_cnt + 1'b1;
    end
    lfsr_next = lfsr;
    if (!hit_r && (replace_mode == MODE_RANDOM)) begin
      lfsr_next = (lfsr >> 1) ^ (lfsr[0] ? LFSR_TAPS : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      access_cnt <= '0;
      hit_cnt    <= '0;
      lfsr       <= LFSR_SEED;
    end else if (cmd.upd) begin
      access_cnt <= access_next;
      hit_cnt    <= hit_next;
      lfsr       <= lfsr_next;
    end
  end

  // Result register; the next item may be accepted while it waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.upd) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      rsp.was_hit      <= hit_r;
      rsp.way_used     <= way_r;
      rsp.access_total <= access_next;
      rsp.hit_total    <= hit_next;
    end
  end

  assign rsp.valid    = rsp_valid;
  assign sts.out_free = !rsp_valid || rsp.ready;
  assign sts.clr_last = (clr_addr == SET_BITS'(NUM_SETS - 1));

  // An update always leaves a result waiting.
  a_upd_gives_rsp: assert property (@(posedge clk) disable iff (rst)
    cmd.upd |=> rsp_valid)
    else $error("update did not produce a result");

  // Hits never outnumber accesses.
  a_hits_le_access: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.hit_total <= rsp.access_total))
    else $error("hit count exceeds access count");

  // A hit result names a way that was valid with the matching tag.
  a_hit_way_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.upd && hit_r) |-> (rd_row.valid[way_r] && (rd_row.tag[way_r] == tag_r)))
    else $error("hit reported on a non-matching way");

endmodule

`default_nettype wire

@@ sv/set_assoc_cache_hit_model.sv @@
// Top level of the set-associative cache hit classifier (LRU or pseudo-random replacement).
// Depends on sach_pkg, sach_if, sach_ctrl and sach_dp.
//
//   Channel  Dir  Payload                                          Transfer
//   req      in   byte_address[47:0]                               valid & ready
//   rsp      out  was_hit, way_used[3:0], access_total, hit_total  valid & ready
//   cfg      in   cfg_wr_data (replace_mode)                       cfg_wr_en
//
// Each address passes through accept with the set memory read, tag compare and victim
// choice, then write-back of the set row together with loading the result register.
// A new address is accepted only after the write-back of the last one.
// After reset a clearing pass writes all 4096 set rows, one per cycle; req.ready is low
// until the pass ends. The update waits while the result register is still full.
`default_nettype none

module set_assoc_cache_hit_model
  import sach_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  sach_req_if.sink   req,
  sach_rsp_if.source rsp,
  input  wire logic  cfg_wr_en,
  input  wire logic  cfg_wr_data
);

  sach_cmd_t cmd;
  sach_sts_t sts;

  sach_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sach_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .req_addr    (req.byte_address),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .rsp         (rsp)
  );

endmodule

`default_nettype wire
